// ----- hdl/wvd_pkg.sv -----
// ----------------------------------------------------------------------------
// wvd_pkg
// Types, codes and the window vote function shared by the debouncer files.
// ----------------------------------------------------------------------------
package wvd_pkg;

	localparam int CFG_W    = 4;
	localparam int CH_W     = 3;
	localparam int HIST_W   = 8;
	localparam int CNT_W    = 4;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [1:0] {
		MODE_SAMPLE = 2'd0,
		MODE_CHECK  = 2'd1,
		MODE_INIT   = 2'd2
	} mode_t;

	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_TIMES   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_VOTE_THRESHOLD = 1'b1;

	localparam logic [CFG_W-1:0] SAMPLE_TIMES_RST   = 4'd5;
	localparam logic [CFG_W-1:0] VOTE_THRESHOLD_RST = 4'd3;

	// status codes: NONE written on init, FELL and ROSE on a level change
	localparam logic [HIST_W-1:0] STAT_NONE = 8'd0;
	localparam logic [HIST_W-1:0] STAT_FELL = 8'd1;
	localparam logic [HIST_W-1:0] STAT_ROSE = 8'd2;

	typedef struct packed {
		logic [1:0]        mode;
		logic [CH_W-1:0]   channel;
		logic              sample_bit;
		logic [HIST_W-1:0] init_bits;
		logic [HIST_W-1:0] expected_status;
		logic [HIST_W-1:0] clear_bits;
	} item_t;

	typedef struct packed {
		logic              level;
		logic [HIST_W-1:0] status;
		logic              matched;
	} result_t;

	// ones among the newest times bits of hist, compared with thr
	function automatic logic vote(input logic [HIST_W-1:0] hist,
			input logic [CFG_W-1:0] times, input logic [CFG_W-1:0] thr);
		logic [HIST_W-1:0] mask;
		logic [HIST_W-1:0] win;
		logic [CNT_W-1:0]  cnt;
		if (times >= CFG_W'(HIST_W)) begin
			mask = '1;
		end else begin
			mask = HIST_W'((9'd1 << times) - 9'd1);
		end
		win = hist & mask;
		cnt = '0;
		for (int i = 0; i < HIST_W; i++) begin
			cnt = cnt + CNT_W'(win[i]);
		end
		return (cnt >= thr);
	endfunction

endpackage

// ----- hdl/wvd_item_if.sv -----
// ----------------------------------------------------------------------------
// wvd_item_if
// Request channel of the debouncer: valid, ready and the request fields.
// ----------------------------------------------------------------------------
interface wvd_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [2:0] channel;
	logic       sample_bit;
	logic [7:0] init_bits;
	logic [7:0] expected_status;
	logic [7:0] clear_bits;

	modport source (output valid, mode, channel, sample_bit, init_bits,
		expected_status, clear_bits, input ready);
	modport sink (input valid, mode, channel, sample_bit, init_bits,
		expected_status, clear_bits, output ready);
endinterface

// ----- hdl/wvd_result_if.sv -----
// ----------------------------------------------------------------------------
// wvd_result_if
// Result channel of the debouncer: valid, ready, level, status and match flag.
// ----------------------------------------------------------------------------
interface wvd_result_if;
	logic       valid;
	logic       ready;
	logic       level;
	logic [7:0] status;
	logic       matched;

	modport source (output valid, level, status, matched, input ready);
	modport sink (input valid, level, status, matched, output ready);
endinterface

// ----- hdl/wvd_state.sv -----
// ----------------------------------------------------------------------------
// wvd_state
// Per-channel history, level and status registers with their update logic.
// ----------------------------------------------------------------------------
module wvd_state #(
	parameter int CHANNELS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         upd,
	input  wvd_pkg::item_t               item,
	input  logic [wvd_pkg::CFG_W-1:0]    sample_times,
	input  logic [wvd_pkg::CFG_W-1:0]    vote_threshold,
	output wvd_pkg::result_t             res
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [wvd_pkg::HIST_W-1:0] hist_q [CHANNELS];
	logic [wvd_pkg::HIST_W-1:0] stat_q [CHANNELS];
	logic [CHANNELS-1:0]        lvl_q;

	logic [IDX_W-1:0]           idx;
	logic                       in_range;
	logic [wvd_pkg::HIST_W-1:0] hist_cur, hist_nxt, stat_cur, stat_nxt, vote_word;
	logic                       lvl_cur, lvl_nxt, vote_now, matched;

	always_comb begin
		idx      = IDX_W'(item.channel);
		in_range = (32'(item.channel) < 32'(CHANNELS));
		hist_cur = in_range ? hist_q[idx] : '0;
		stat_cur = in_range ? stat_q[idx] : '0;
		lvl_cur  = in_range ? lvl_q[idx] : 1'b0;

		// init votes on the loaded word, sample on the shifted history
		if (item.mode == wvd_pkg::MODE_INIT) begin
			vote_word = item.init_bits;
		end else begin
			vote_word = {hist_cur[wvd_pkg::HIST_W-2:0], item.sample_bit};
		end
		vote_now = wvd_pkg::vote(vote_word, sample_times, vote_threshold);

		hist_nxt = hist_cur;
		stat_nxt = stat_cur;
		lvl_nxt  = lvl_cur;
		matched  = 1'b0;
		case (wvd_pkg::mode_t'(item.mode))
			wvd_pkg::MODE_SAMPLE: begin
				hist_nxt = vote_word;
				if (vote_now != lvl_cur) begin
					lvl_nxt  = vote_now;
					stat_nxt = vote_now ? wvd_pkg::STAT_ROSE : wvd_pkg::STAT_FELL;
				end
			end
			wvd_pkg::MODE_CHECK: begin
				if (stat_cur == item.expected_status) begin
					stat_nxt = stat_cur | item.clear_bits;
					matched  = in_range;
				end
			end
			wvd_pkg::MODE_INIT: begin
				hist_nxt = vote_word;
				lvl_nxt  = vote_now;
				stat_nxt = wvd_pkg::STAT_NONE;
			end
			default: begin
			end
		endcase

		res.level   = in_range & lvl_nxt;
		res.status  = in_range ? stat_nxt : '0;
		res.matched = matched;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				hist_q[i] <= '0;
				stat_q[i] <= '0;
			end
			lvl_q <= '0;
		end else if (upd && in_range) begin
			hist_q[idx] <= hist_nxt;
			stat_q[idx] <= stat_nxt;
			lvl_q[idx]  <= lvl_nxt;
		end
	end

endmodule

// ----- hdl/window_vote_input_debouncer.sv -----
// ----------------------------------------------------------------------------
// window_vote_input_debouncer
// Multi-channel window vote debouncer with request and result channels.
// ----------------------------------------------------------------------------
// Requests enter on item (valid/ready) and name a channel and a mode: sample
// shifts a raw bit into the channel history and re-votes the level, check
// compares the status byte and ORs in marks on a match, init loads a whole
// history word. Every request gives one result on the result channel.
// The request is registered, then one pass through the popcount/compare and
// the channel state update writes the result register unless that register
// is stalled; one request per cycle is taken while the receiver does not
// stall, since the channel state is updated in the same cycle it is read.
// When the receiver stalls, the result register holds and the request
// register behind it holds too; ready drops only while both are full.
// The config port writes sample_times (index 0) and vote_threshold (index 1);
// the user must write it only while the block is idle, which is not enforced.
// Reset clears all channel histories, levels and status bytes, empties both
// registers and returns the config to 5 and 3.
// ----------------------------------------------------------------------------
module window_vote_input_debouncer #(
	parameter int CHANNELS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	wvd_item_if.sink                            item,
	wvd_result_if.source                        result,
	input  logic                                cfg_we,
	input  logic [wvd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wvd_pkg::CFG_W-1:0]           cfg_data
);

	logic [wvd_pkg::CFG_W-1:0] sample_times_q, vote_threshold_q;
	wvd_pkg::item_t            item_s1;
	logic                      valid_s1;
	wvd_pkg::result_t          res_comb, result_q;
	logic                      res_valid_q;
	logic                      adv;

	assign adv        = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_times_q   <= wvd_pkg::SAMPLE_TIMES_RST;
			vote_threshold_q <= wvd_pkg::VOTE_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				wvd_pkg::CFG_SAMPLE_TIMES:   sample_times_q   <= cfg_data;
				wvd_pkg::CFG_VOTE_THRESHOLD: vote_threshold_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (adv) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.mode            <= item.mode;
			item_s1.channel         <= item.channel;
			item_s1.sample_bit      <= item.sample_bit;
			item_s1.init_bits       <= item.init_bits;
			item_s1.expected_status <= item.expected_status;
			item_s1.clear_bits      <= item.clear_bits;
		end
		if (adv) begin
			result_q <= res_comb;
		end
	end

	wvd_state #(
		.CHANNELS (CHANNELS)
	) u_state (
		.clk            (clk),
		.arst_n         (arst_n),
		.upd            (adv),
		.item           (item_s1),
		.sample_times   (sample_times_q),
		.vote_threshold (vote_threshold_q),
		.res            (res_comb)
	);

	assign result.valid   = res_valid_q;
	assign result.level   = result_q.level;
	assign result.status  = result_q.status;
	assign result.matched = result_q.matched;

endmodule

// ----- hdl/wvd_checker.sv -----
// ----------------------------------------------------------------------------
// wvd_checker
// Port-level checks of the debouncer handshake and latency.
// ----------------------------------------------------------------------------
module wvd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic       res_level,
	input logic [7:0] res_status,
	input logic       res_matched
);

	// a stalled result stays and holds its fields
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_level)
			&& $stable(res_status) && $stable(res_matched))
		else $error("result changed while stalled");

	a_rst_empty: assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result valid during reset");

	// every taken request must be followed by a valid result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |-> ##2 res_valid)
		else $error("result missing two cycles after request");

	// with the result register empty the block always takes a request
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> item_ready)
		else $error("request refused with empty result register");

endmodule

bind window_vote_input_debouncer wvd_checker u_wvd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item.valid),
	.item_ready  (item.ready),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_level   (result.level),
	.res_status  (result.status),
	.res_matched (result.matched)
);
